// ===== rtl/hcbd_pkg.sv =====
package hcbd_pkg;

    localparam int SIZE_BITS = 32;

    localparam int PHASE_BITS = 3;
    localparam logic [PHASE_BITS-1:0] PH_LEAD   = 3'd0;
    localparam logic [PHASE_BITS-1:0] PH_DIGITS = 3'd1;
    localparam logic [PHASE_BITS-1:0] PH_EXT    = 3'd2;
    localparam logic [PHASE_BITS-1:0] PH_DATA   = 3'd3;
    localparam logic [PHASE_BITS-1:0] PH_SKIP   = 3'd4;
    localparam logic [PHASE_BITS-1:0] PH_TAIL   = 3'd5;
    localparam logic [PHASE_BITS-1:0] PH_LEFT   = 3'd6;

    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_END      = 2'd1;
    localparam logic [1:0] KIND_LEFTOVER = 2'd2;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam logic [1:0] SKIP_BYTES = 2'd2;

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QLVL_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } step_res_t;

    function automatic logic is_hex(input logic [7:0] b);
        is_hex = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66)
              || (b >= 8'h41 && b <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] v;
        v = 8'h00;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            v = b - 8'h30;
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            v = b - 8'h57;
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            v = b - 8'h37;
        end
        hex_val = v[3:0];
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        is_blank = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

endpackage

// ===== rtl/hcbd_if.sv =====
interface hcbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       new_message;

    modport source (output valid, output byte_in, output new_message, input ready);
    modport sink (input valid, input byte_in, input new_message, output ready);
endinterface

interface hcbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;

    modport source (output valid, output out_byte, output kind, input ready);
    modport sink (input valid, input out_byte, input kind, output ready);
endinterface

// ===== rtl/hcbd_step.sv =====
module hcbd_step
    import hcbd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic [7:0]      byte_in,
    input  logic            new_message,
    output step_res_t       step_res
);

    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [SIZE_BITS-1:0]  chunk_reg, chunk_next;
    logic                  cr_reg, cr_next;
    logic [1:0]            skip_reg, skip_next;

    logic [PHASE_BITS-1:0] ph;
    logic [SIZE_BITS-1:0]  chunk;
    logic                  cr;
    logic [1:0]            skip;
    logic [1:0]            skip_dec;
    logic [SIZE_BITS-1:0]  chunk_acc;

    // new message restarts decoding on this byte
    assign ph    = new_message ? PH_LEAD : phase_reg;
    assign chunk = new_message ? '0 : chunk_reg;
    assign cr    = new_message ? 1'b0 : cr_reg;
    assign skip  = new_message ? 2'd0 : skip_reg;

    // shift in one hex digit, saturating at all ones
    assign chunk_acc = (chunk[SIZE_BITS-1 -: 4] != 4'd0) ? '1
                     : {chunk[SIZE_BITS-5:0], hex_val(byte_in)};
    assign skip_dec  = (skip != 2'd0) ? skip - 2'd1 : skip;

    always_comb
    begin
        phase_next = ph;
        chunk_next = chunk;
        cr_next    = cr;
        skip_next  = skip;
        step_res   = '0;
        case (ph)
            PH_LEAD, PH_DIGITS, PH_EXT:
            begin
                if (cr && byte_in == CH_LF)
                begin
                    cr_next = 1'b0;
                    if (chunk == '0)
                    begin
                        step_res.count = 2'd1;
                        step_res.first = '{out_byte: 8'h00, kind: KIND_END};
                        phase_next     = PH_TAIL;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                else
                begin
                    cr_next = (byte_in == CH_CR);
                    if (ph == PH_LEAD)
                    begin
                        if (!is_blank(byte_in))
                        begin
                            if (is_hex(byte_in))
                            begin
                                phase_next = PH_DIGITS;
                                chunk_next = chunk_acc;
                            end
                            else
                            begin
                                phase_next = PH_EXT;
                            end
                        end
                    end
                    else if (ph == PH_DIGITS)
                    begin
                        if (is_hex(byte_in))
                        begin
                            chunk_next = chunk_acc;
                        end
                        else
                        begin
                            phase_next = PH_EXT;
                        end
                    end
                end
            end
            PH_DATA:
            begin
                step_res.count = 2'd1;
                step_res.first = '{out_byte: byte_in, kind: KIND_PAYLOAD};
                chunk_next     = chunk - 1'b1;
                if (chunk == {{(SIZE_BITS-1){1'b0}}, 1'b1})
                begin
                    phase_next = PH_SKIP;
                    skip_next  = SKIP_BYTES;
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 2'd0)
                begin
                    phase_next = PH_LEAD;
                    chunk_next = '0;
                    cr_next    = 1'b0;
                end
            end
            PH_TAIL:
            begin
                if (cr)
                begin
                    cr_next    = 1'b0;
                    phase_next = PH_LEFT;
                    if (byte_in != CH_LF)
                    begin
                        step_res.count  = 2'd2;
                        step_res.first  = '{out_byte: CH_CR, kind: KIND_LEFTOVER};
                        step_res.second = '{out_byte: byte_in, kind: KIND_LEFTOVER};
                    end
                end
                else if (byte_in == CH_CR)
                begin
                    cr_next = 1'b1;
                end
                else
                begin
                    step_res.count = 2'd1;
                    step_res.first = '{out_byte: byte_in, kind: KIND_LEFTOVER};
                    phase_next     = PH_LEFT;
                end
            end
            default:
            begin
                phase_next     = PH_LEFT;
                step_res.count = 2'd1;
                step_res.first = '{out_byte: byte_in, kind: KIND_LEFTOVER};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            chunk_reg <= '0;
            cr_reg    <= 1'b0;
            skip_reg  <= 2'd0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            chunk_reg <= chunk_next;
            cr_reg    <= cr_next;
            skip_reg  <= skip_next;
        end
    end

endmodule

// ===== rtl/hcbd_outq.sv =====
module hcbd_outq
    import hcbd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  step_res_t            step_res,
    input  logic                 pop,
    output result_t              head,
    output logic [QLVL_BITS-1:0] level
);

    result_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QLVL_BITS-1:0]  level_reg;
    logic [1:0]            n_push;
    logic [QPTR_BITS-1:0]  wr_ptr_nxt1;

    assign n_push      = push ? step_res.count : 2'd0;
    assign wr_ptr_nxt1 = wr_ptr_reg + 1'b1;
    assign head        = entry_reg[rd_ptr_reg];
    assign level       = level_reg;

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= step_res.first;
        end
        if (n_push == 2'd2)
        begin
            entry_reg[wr_ptr_nxt1] <= step_res.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(n_push);
            rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(pop);
            level_reg  <= level_reg + QLVL_BITS'(n_push) - QLVL_BITS'(pop);
        end
    end

endmodule

// ===== rtl/http_chunked_body_decoder_core.sv =====
// chunked body decoder: strips the size lines and trailing CR LF of each chunk
// and passes the payload bytes on
//
// in_ch  : one body byte per transfer, with new_message set on the first byte
//          of a new body (it clears all decoder state before that byte)
// out_ch : one result per transfer: payload byte (kind 0), end of body marker
//          with zero byte (kind 1), or a byte after the body (kind 2)
//
// data path: a byte taken into the input register is decoded and written to
// the result queue, whose head drives out_ch
// throughput: one byte per cycle while the result queue has room for two
// results; a byte that gives two results (a CR that turns out not to begin
// CR LF after the end marker) sends them one at a time through the single
// output port of the four-entry result queue
//
// reset: decoder waits for a size line, input register and queue are empty
// receiver stall: results pile up in the queue; the decoder stops when fewer
// than two entries are free, and in_ch.ready drops once the input register
// holds a byte that cannot move on
module http_chunked_body_decoder_core
    import hcbd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    hcbd_in_if.sink   in_ch,
    hcbd_out_if.source out_ch
);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_new_reg;

    logic                 advance;
    step_res_t            step_res;
    result_t              head;
    logic [QLVL_BITS-1:0] level;
    logic                 pop;

    // decode only when the queue can take the worst case of two results
    assign advance      = in_valid_reg && (level <= QLVL_BITS'(QUEUE_DEPTH - 2));
    assign in_ch.ready  = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    // payload held while the decoder is blocked
    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            in_byte_reg <= in_ch.byte_in;
            in_new_reg  <= in_ch.new_message;
        end
    end

    hcbd_step u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .byte_in     (in_byte_reg),
        .new_message (in_new_reg),
        .step_res    (step_res)
    );

    hcbd_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (advance),
        .step_res (step_res),
        .pop      (pop),
        .head     (head),
        .level    (level)
    );

    assign pop             = out_ch.valid && out_ch.ready;
    assign out_ch.valid    = (level != '0);
    assign out_ch.out_byte = head.out_byte;
    assign out_ch.kind     = head.kind;

    // queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        level <= QLVL_BITS'(QUEUE_DEPTH))
        else $error("result queue overflow");

    // a blocked byte stays in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("blocked input byte lost");

    // every queued result carries a defined kind
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.kind == KIND_PAYLOAD || out_ch.kind == KIND_END
                          || out_ch.kind == KIND_LEFTOVER))
        else $error("bad result kind");

    // a decode step with a result always leaves something to send
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_res.count != 2'd0) |=> out_ch.valid)
        else $error("decoded result not queued");

endmodule

// ===== tb/testbench.sv =====
module testbench;
    import hcbd_pkg::*;

    // stimulus volume and pacing
    localparam int RANDOM_BYTES     = 1250;
    localparam int QUIET_TAIL       = 150;
    localparam int LONG_HOLD_AT     = 300;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES     = 20;
    localparam int MAX_REPORTS      = 10;

    // one body byte waiting to be offered on the input channel
    typedef struct packed {
        logic [7:0] data;
        logic       first;  // new_message on this byte
        logic       hold;   // wait until every result so far has come back
    } body_item_t;

    logic clk = 1'b0;
    logic rst_n;

    hcbd_in_if  in_ch ();
    hcbd_out_if out_ch ();

    http_chunked_body_decoder_core dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // shared bookkeeping
    // ------------------------------------------------------------------
    body_item_t tx_q[$];           // bytes still to be sent
    result_t    expected_q[$];     // decoded results not yet seen on out_ch
    int         results_due;       // results predicted so far (nonblocking)
    int         results_seen;      // results taken from out_ch (nonblocking)
    int         bytes_sent;        // input transfers so far (nonblocking)
    int         errors = 0;
    int         tx_gap;
    int         rx_gap;
    int         rx_hold_left;
    logic       rx_hold_done;
    logic       no_idle;           // both sides stop idling while set

    // stimulus build state
    logic       start_next = 1'b0;
    logic       hold_next = 1'b0;
    int         cut_left = -1;     // bytes left before a body is cut short, -1 for none

    // ------------------------------------------------------------------
    // decoder prediction: own copy of the chunked decoding state
    // ------------------------------------------------------------------
    logic [PHASE_BITS-1:0] dec_phase;
    logic [SIZE_BITS-1:0]  chunk_left;   // size being read, then bytes left in the chunk
    logic                  cr_seen;      // previous byte was a CR that may open CR LF
    logic [1:0]            drop_left;    // bytes still to throw away after a chunk

    function automatic void clear_decoder();
        dec_phase  = PH_LEAD;
        chunk_left = '0;
        cr_seen    = 1'b0;
        drop_left  = 2'd0;
    endfunction

    function automatic int hex_nibble(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39)
        begin
            return int'(b - 8'h30);
        end
        if (b >= 8'h61 && b <= 8'h66)
        begin
            return int'(b - 8'h57);
        end
        if (b >= 8'h41 && b <= 8'h46)
        begin
            return int'(b - 8'h37);
        end
        return -1;
    endfunction

    // space, tab, LF, VT, FF and CR all count as leading blanks
    function automatic logic line_blank(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic void note_result(input logic [7:0] b, input logic [1:0] k);
        result_t r;
        r.out_byte = b;
        r.kind     = k;
        expected_q.push_back(r);
    endfunction

    // one character of a size line that is not the LF closing it
    function automatic void size_line_char(input logic [7:0] b);
        int         d;
        logic [3:0] nib;
        d = hex_nibble(b);
        if (dec_phase == PH_LEAD)
        begin
            if (line_blank(b))
            begin
                return;
            end
            if (d < 0)
            begin
                dec_phase = PH_EXT;
                return;
            end
            dec_phase = PH_DIGITS;
        end
        else if (dec_phase == PH_EXT)
        begin
            return;
        end
        else if (d < 0)
        begin
            dec_phase = PH_EXT;
            return;
        end
        nib = d[3:0];
        // saturate once another digit would shift bits out of the top
        if (|chunk_left[SIZE_BITS-1 -: 4])
        begin
            chunk_left = '1;
        end
        else
        begin
            chunk_left = {chunk_left[SIZE_BITS-5:0], nib};
        end
    endfunction

    // decodes one accepted byte and returns how many results it adds
    function automatic int decode_byte(input logic [7:0] b, input logic first);
        int before_n;
        before_n = expected_q.size();
        if (first)
        begin
            clear_decoder();
        end
        case (dec_phase)
            PH_LEAD, PH_DIGITS, PH_EXT:
            begin
                if (cr_seen && b == CH_LF)
                begin
                    cr_seen = 1'b0;
                    if (chunk_left == '0)
                    begin
                        note_result(8'h00, KIND_END);
                        dec_phase = PH_TAIL;
                    end
                    else
                    begin
                        dec_phase = PH_DATA;
                    end
                end
                else
                begin
                    size_line_char(b);
                    cr_seen = (b == CH_CR);
                end
            end
            PH_DATA:
            begin
                note_result(b, KIND_PAYLOAD);
                chunk_left = chunk_left - 1'b1;
                if (chunk_left == '0)
                begin
                    dec_phase = PH_SKIP;
                    drop_left = SKIP_BYTES;
                end
            end
            PH_SKIP:
            begin
                if (drop_left != 2'd0)
                begin
                    drop_left = drop_left - 2'd1;
                end
                if (drop_left == 2'd0)
                begin
                    dec_phase  = PH_LEAD;
                    chunk_left = '0;
                    cr_seen    = 1'b0;
                end
            end
            PH_TAIL:
            begin
                // a CR LF right after the end marker is swallowed, anything else
                // starts the leftovers
                if (cr_seen)
                begin
                    cr_seen = 1'b0;
                    if (b != CH_LF)
                    begin
                        note_result(CH_CR, KIND_LEFTOVER);
                        note_result(b, KIND_LEFTOVER);
                    end
                    dec_phase = PH_LEFT;
                end
                else if (b == CH_CR)
                begin
                    cr_seen = 1'b1;
                end
                else
                begin
                    note_result(b, KIND_LEFTOVER);
                    dec_phase = PH_LEFT;
                end
            end
            default:
            begin
                dec_phase = PH_LEFT;
                note_result(b, KIND_LEFTOVER);
            end
        endcase
        return expected_q.size() - before_n;
    endfunction

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    task automatic put_byte(input logic [7:0] b);
        body_item_t it;
        if (cut_left == 0)
        begin
            return;
        end
        if (cut_left > 0)
        begin
            cut_left--;
        end
        it.data  = b;
        it.first = start_next;
        it.hold  = hold_next;
        start_next = 1'b0;
        hold_next  = 1'b0;
        tx_q.push_back(it);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            put_byte(s[i]);
        end
    endtask

    task automatic put_crlf();
        put_byte(CH_CR);
        put_byte(CH_LF);
    endtask

    // size line: optional blanks and zeros, hex digits in mixed case,
    // sometimes an extension, then CR LF
    task automatic put_size_line(input int unsigned size);
        int         top;
        logic [3:0] nib;
        logic [7:0] ch;
        repeat ($urandom_range(0, 2))
        begin
            case ($urandom_range(0, 3))
                0: put_byte(8'h20);
                1: put_byte(8'h09);
                2: put_byte(8'h0B);
                default: put_byte(8'h0C);
            endcase
        end
        repeat ($urandom_range(0, 1))
        begin
            put_byte(8'h30);
        end
        top = 7;
        while (top > 0 && size[4*top +: 4] == 4'd0)
        begin
            top--;
        end
        for (int k = top; k >= 0; k--)
        begin
            nib = size[4*k +: 4];
            if (nib < 4'd10)
            begin
                ch = 8'h30 + nib;
            end
            else
            begin
                ch = (($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + nib - 8'd10;
            end
            put_byte(ch);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            put_byte(8'h3B);
            repeat ($urandom_range(1, 4))
            begin
                put_byte(8'($urandom_range(8'h21, 8'h7E)));
            end
        end
        put_crlf();
    endtask

    // a whole chunked body, cut short after a given number of bytes if cut >= 0
    task automatic put_chunked_body(input int cut);
        int unsigned size;
        logic [7:0]  b;
        cut_left   = cut;
        start_next = 1'b1;
        repeat ($urandom_range(0, 3))
        begin
            size = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
            put_size_line(size);
            repeat (size)
            begin
                put_byte(8'($urandom_range(0, 255)));
            end
            // the two bytes after a chunk are dropped whatever they hold
            if ($urandom_range(0, 6) == 0)
            begin
                put_byte(8'($urandom_range(0, 255)));
                put_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                put_crlf();
            end
        end
        put_size_line(0);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: put_crlf();
            4, 5:
            begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_LF)
                begin
                    b = 8'h00;
                end
                put_byte(CH_CR);
                put_byte(b);
            end
            default: ;
        endcase
        repeat ($urandom_range(0, 3))
        begin
            put_byte(8'($urandom_range(0, 255)));
        end
        cut_left = -1;
    endtask

    task automatic put_noise();
        start_next = 1'b1;
        repeat ($urandom_range(1, 12))
        begin
            start_next = start_next | ($urandom_range(0, 19) == 0);
            put_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic flag_error(input string what);
        errors++;
        if (errors <= MAX_REPORTS)
        begin
            $display("ERROR at %0t: %s", $time, what);
        end
    endtask

    // ------------------------------------------------------------------
    // driver: offers queued bytes on in_ch, predicts on every input transfer
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        logic       offer;
        logic       took;
        int         n_new;
        body_item_t nxt;
        if (!rst_n)
        begin
            in_ch.valid       <= 1'b0;
            in_ch.byte_in     <= 8'h00;
            in_ch.new_message <= 1'b0;
            tx_gap            <= 0;
            bytes_sent        <= 0;
            results_due       <= 0;
            no_idle           <= 1'b0;
            clear_decoder();
            expected_q.delete();
        end
        else
        begin
            took  = in_ch.valid && in_ch.ready;
            offer = in_ch.valid && !took;
            if (took)
            begin
                n_new = decode_byte(in_ch.byte_in, in_ch.new_message);
                results_due <= results_due + n_new;
                bytes_sent  <= bytes_sent + 1;
            end
            if (!offer)
            begin
                if (tx_gap != 0)
                begin
                    tx_gap <= tx_gap - 1;
                end
                else if (tx_q.size() != 0
                         && !(tx_q[0].hold && (took || results_seen != results_due)))
                begin
                    // sometimes start an idle burst instead of offering the next byte
                    if (!no_idle && $urandom_range(0, 9) == 0)
                    begin
                        tx_gap <= $urandom_range(0, 14);
                    end
                    else
                    begin
                        nxt = tx_q.pop_front();
                        in_ch.byte_in     <= nxt.data;
                        in_ch.new_message <= nxt.first;
                        offer = 1'b1;
                    end
                end
            end
            in_ch.valid <= offer;
            // no idling at the end of the run, nor in a window of every 400 bytes
            no_idle <= (tx_q.size() < QUIET_TAIL) || (bytes_sent % 400 >= 330);
        end
    end

    // ------------------------------------------------------------------
    // long receiver hold-off, so the result queue fills and in_ch stalls
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_hold_left <= 0;
            rx_hold_done <= 1'b0;
        end
        else if (rx_hold_left != 0)
        begin
            rx_hold_left <= rx_hold_left - 1;
        end
        else if (!rx_hold_done && bytes_sent >= LONG_HOLD_AT)
        begin
            rx_hold_left <= LONG_HOLD_CYCLES;
            rx_hold_done <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each output transfer against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        logic    rdy;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            rx_gap       <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                // only predictions made at earlier edges are due
                if (results_seen == results_due)
                begin
                    flag_error($sformatf("unexpected result byte %02h kind %0d",
                                         out_ch.out_byte, out_ch.kind));
                end
                else
                begin
                    want = expected_q.pop_front();
                    results_seen <= results_seen + 1;
                    if (out_ch.out_byte !== want.out_byte || out_ch.kind !== want.kind)
                    begin
                        flag_error($sformatf(
                            "result %0d: expected byte %02h kind %0d, got byte %02h kind %0d",
                            results_seen, want.out_byte, want.kind,
                            out_ch.out_byte, out_ch.kind));
                    end
                end
            end
            rdy = 1'b1;
            if (rx_gap != 0)
            begin
                rx_gap <= rx_gap - 1;
                rdy = 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 11) == 0)
            begin
                rx_gap <= $urandom_range(0, 14);
                rdy = 1'b0;
            end
            if (rx_hold_left != 0)
            begin
                rdy = 1'b0;
            end
            out_ch.ready <= rdy;
        end
    end

    // ------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int directed_n;
        int pick;
        rst_n = 1'b0;

        // lone CR and lone LF on a size line, extension, extreme data bytes,
        // dropped bytes after a chunk that are not CR LF, end marker, then a
        // CR followed by something other than LF giving two leftovers
        start_next = 1'b1;
        put_byte(CH_CR);
        put_text("2;");
        put_byte(CH_LF);
        put_crlf();
        put_byte(8'h00);
        put_byte(8'hFF);
        put_text("xy0");
        put_crlf();
        put_byte(CH_CR);
        put_text("A");
        // a 0x prefix ends the digits at the x, CR LF after the marker absorbed
        start_next = 1'b1;
        put_text("0x");
        put_crlf();
        put_crlf();
        // size too wide for the counter saturates, one payload byte follows
        start_next = 1'b1;
        put_text("fFfFfFfFf");
        put_crlf();
        put_byte(8'h55);
        directed_n = tx_q.size();

        // random bodies; the first one waits for every directed result
        hold_next = 1'b1;
        while (tx_q.size() < directed_n + RANDOM_BYTES)
        begin
            if ($urandom_range(0, 99) < 3)
            begin
                hold_next = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 85)
            begin
                put_chunked_body(-1);
            end
            else if (pick < 93)
            begin
                put_chunked_body($urandom_range(1, 30));
            end
            else
            begin
                put_noise();
            end
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (tx_q.size() == 0 && in_ch.valid == 1'b0);
        wait (results_seen == results_due);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (results_seen != results_due)
        begin
            flag_error($sformatf("%0d results never arrived", results_due - results_seen));
        end
        if (errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog far beyond the slowest legal run
    initial
    begin
        #1000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
